// ===== hw/rtl/ps2s1_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2s1_pkg: shared types and constants for the set-1 scan code converter
// Holds scan code values, the US key tables and the op format passed from
// the front decoder to the back character ring.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2s1_pkg;

  // Scan code values
  localparam logic [7:0] CODE_EXTENDED = 8'hE0;
  localparam logic [6:0] CODE_LSHIFT   = 7'h2A;
  localparam logic [6:0] CODE_RSHIFT   = 7'h36;
  localparam logic [6:0] CODE_CTRL     = 7'h1D;
  localparam logic [6:0] CODE_CAPS     = 7'h3A;
  localparam logic [6:0] CODE_KEY_C    = 7'h2E;

  // Characters and case handling
  localparam logic [6:0] CHAR_ETX    = 7'h03;
  localparam logic [6:0] CASE_DELTA  = 7'd32;
  localparam logic [6:0] CHAR_LO_A   = 7'h61;
  localparam logic [6:0] CHAR_LO_Z   = 7'h7A;
  localparam logic [6:0] CHAR_UP_A   = 7'h41;
  localparam logic [6:0] CHAR_UP_Z   = 7'h5A;

  // Key tables
  localparam int unsigned TAB_SIZE = 58;

  localparam logic [6:0] PLAIN_TAB [TAB_SIZE] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20
  };

  localparam logic [6:0] SHIFT_TAB [TAB_SIZE] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20
  };

  // Op queue between front and back
  localparam int unsigned OPQ_AW    = 2;
  localparam int unsigned OPQ_DEPTH = 1 << OPQ_AW;

  // Output skid buffer
  localparam int unsigned OB_DEPTH = 2;

  // One op handed from the front decoder to the back ring
  typedef struct packed {
    logic       is_read;  // pop a character from the ring
    logic [6:0] ch;       // character to push when not a read
  } op_t;

  // Look up a key code; codes past the table give no character
  function automatic logic [6:0] key_lookup(input logic [6:0] code, input logic shifted);
    logic [6:0] ch;
    ch = 7'h00;
    if (code < 7'(TAB_SIZE)) begin
      ch = shifted ? SHIFT_TAB[code[5:0]] : PLAIN_TAB[code[5:0]];
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ps2_set1_scancode_to_ascii_fifo_top.sv =====
// ----------------------------------------------------------------------------
// ps2_set1_scancode_to_ascii_fifo_top: set-1 scan code to ASCII with queue
// Decodes set-1 scan codes (US layout) into characters, buffers them in a
// ring and returns the oldest one on each read request.
//
//   channel  | handshake          | beat
//   ---------+--------------------+------------------------------------
//   input    | push / full        | kind, scan_code
//   result   | empty / pop        | ascii_char, queue_empty (read only)
//
// One beat per cycle in while full is low, one result per cycle out while
// results wait; a read result is registered in the op queue, the ring read
// port and the output buffer before it reaches the result ports to be popped.
// full rises only when the four-entry op queue between decoder and ring
// fills, i.e. when results are not popped. Reset is synchronous and clears
// modifiers, pointers and queues; ring contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_set1_scancode_to_ascii_fifo_top #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic       kind,
  input  wire logic [7:0] scan_code,
  output logic            empty,
  input  wire logic       pop,
  output logic [6:0]      ascii_char,
  output logic            queue_empty
);

  ps2s1_pkg::op_t front_op;
  logic           front_valid;
  ps2s1_pkg::op_t head_op;
  logic           head_valid;
  logic           head_take;

  // Decode scan codes and requests
  ps2s1_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .kind      (kind),
    .scan_code (scan_code),
    .opq_full  (full),
    .op        (front_op),
    .op_valid  (front_valid)
  );

  // Decouple decoder from ring
  ps2s1_opq u_opq (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_op    (front_op),
    .full     (full),
    .rd_valid (head_valid),
    .rd_op    (head_op),
    .rd_take  (head_take)
  );

  // Execute ops against the character ring
  ps2s1_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .op_valid    (head_valid),
    .op          (head_op),
    .op_take     (head_take),
    .empty       (empty),
    .pop         (pop),
    .ascii_char  (ascii_char),
    .queue_empty (queue_empty)
  );

  // Check the result port
  ps2s1_opq_unused_guard u_chk (
    .clk         (clk),
    .rst         (rst),
    .empty       (empty),
    .pop         (pop),
    .ascii_char  (ascii_char),
    .queue_empty (queue_empty)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/ps2s1_front.sv =====
// ----------------------------------------------------------------------------
// ps2s1_front: scan code decoder
// Tracks shift, ctrl and caps lock, turns key presses into characters and
// emits one op per produced character or read request.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2s1_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic             kind,
  input  wire logic [7:0]       scan_code,
  input  wire logic             opq_full,
  output ps2s1_pkg::op_t        op,
  output logic                  op_valid
);

  logic       shift_held;
  logic       caps_on;
  logic       ctrl_held;
  logic       shift_held_next;
  logic       caps_on_next;
  logic       ctrl_held_next;
  logic       accept;
  logic       release_bit;
  logic [6:0] code;
  logic [6:0] ch_raw;
  logic [6:0] ch_cased;

  assign accept      = push && !opq_full;
  assign release_bit = scan_code[7];
  assign code        = scan_code[6:0];

  // Table lookup and caps flip of letters
  always_comb begin
    ch_raw   = ps2s1_pkg::key_lookup(code, shift_held);
    ch_cased = ch_raw;
    if (caps_on) begin
      if (ch_raw >= ps2s1_pkg::CHAR_LO_A && ch_raw <= ps2s1_pkg::CHAR_LO_Z) begin
        ch_cased = ch_raw - ps2s1_pkg::CASE_DELTA;
      end else if (ch_raw >= ps2s1_pkg::CHAR_UP_A && ch_raw <= ps2s1_pkg::CHAR_UP_Z) begin
        ch_cased = ch_raw + ps2s1_pkg::CASE_DELTA;
      end
    end
  end

  // Classify the beat: modifier update, character, read or nothing
  always_comb begin
    shift_held_next = shift_held;
    caps_on_next    = caps_on;
    ctrl_held_next  = ctrl_held;
    op_valid        = 1'b0;
    op.is_read      = 1'b0;
    op.ch           = ch_cased;
    if (accept) begin
      if (kind) begin
        op_valid   = 1'b1;
        op.is_read = 1'b1;
      end else if (scan_code == ps2s1_pkg::CODE_EXTENDED) begin
        op_valid = 1'b0;
      end else if (code == ps2s1_pkg::CODE_LSHIFT || code == ps2s1_pkg::CODE_RSHIFT) begin
        shift_held_next = !release_bit;
      end else if (code == ps2s1_pkg::CODE_CTRL) begin
        ctrl_held_next = !release_bit;
      end else if (code == ps2s1_pkg::CODE_CAPS && !release_bit) begin
        caps_on_next = !caps_on;
      end else if (release_bit) begin
        op_valid = 1'b0;
      end else if (ctrl_held && code == ps2s1_pkg::CODE_KEY_C) begin
        op_valid = 1'b1;
        op.ch    = ps2s1_pkg::CHAR_ETX;
      end else begin
        op_valid = (ch_cased != 7'h00);
      end
    end
  end

  // Hold modifier flags
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
      caps_on    <= 1'b0;
      ctrl_held  <= 1'b0;
    end else begin
      shift_held <= shift_held_next;
      caps_on    <= caps_on_next;
      ctrl_held  <= ctrl_held_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ps2s1_opq.sv =====
// ----------------------------------------------------------------------------
// ps2s1_opq: op queue between decoder and character ring
// Small flop FIFO that lets the front and back stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2s1_opq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_valid,
  input  wire ps2s1_pkg::op_t   wr_op,
  output logic                  full,
  output logic                  rd_valid,
  output ps2s1_pkg::op_t        rd_op,
  input  wire logic             rd_take
);

  localparam int unsigned CW = $clog2(ps2s1_pkg::OPQ_DEPTH + 1);

  ps2s1_pkg::op_t                  slots [ps2s1_pkg::OPQ_DEPTH];
  logic [ps2s1_pkg::OPQ_AW-1:0]    wr_ptr;
  logic [ps2s1_pkg::OPQ_AW-1:0]    rd_ptr;
  logic [CW-1:0]                   count;
  logic                            do_wr;
  logic                            do_rd;

  assign full     = (count == CW'(ps2s1_pkg::OPQ_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_op    = slots[rd_ptr];
  assign do_wr    = wr_valid && !full;
  assign do_rd    = rd_take && rd_valid;

  // Store ops
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_op;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Count stays within the queue and matches the pointer distance
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ps2s1_pkg::OPQ_DEPTH))
    else $error("op queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == count[ps2s1_pkg::OPQ_AW-1:0])
    else $error("op queue pointers disagree with count");

  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    rd_take |-> rd_valid)
    else $error("op taken from empty queue");

endmodule

`default_nettype wire

// ===== hw/rtl/ps2s1_back.sv =====
// ----------------------------------------------------------------------------
// ps2s1_back: character ring and result buffer
// Executes ops in order: pushes characters into the ring (dropping them when
// full) and serves reads into a two-entry output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2s1_back #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             op_valid,
  input  wire ps2s1_pkg::op_t   op,
  output logic                  op_take,
  output logic                  empty,
  input  wire logic             pop,
  output logic [6:0]            ascii_char,
  output logic                  queue_empty
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Character ring
  logic [6:0]    ring [QUEUE_DEPTH];
  logic [PW-1:0] write_pointer;
  logic [PW-1:0] read_pointer;
  logic [PW-1:0] wp_inc;
  logic [PW-1:0] rp_inc;
  logic          ring_full;
  logic          ring_empty;

  // Read in flight
  logic          p_valid;
  logic          p_empty;
  logic [6:0]    rd_data;

  // Output buffer
  logic [6:0]    ob_ch    [ps2s1_pkg::OB_DEPTH];
  logic          ob_empty [ps2s1_pkg::OB_DEPTH];
  logic          ob_wr;
  logic          ob_rd;
  logic [1:0]    ob_cnt;
  logic [1:0]    inflight;
  logic          pop_fire;
  logic          issue_ok;
  logic          do_write;
  logic          do_read;

  assign wp_inc     = (write_pointer == PW'(QUEUE_DEPTH - 1)) ? '0 : write_pointer + 1'b1;
  assign rp_inc     = (read_pointer == PW'(QUEUE_DEPTH - 1)) ? '0 : read_pointer + 1'b1;
  assign ring_full  = (wp_inc == read_pointer);
  assign ring_empty = (write_pointer == read_pointer);

  assign empty       = (ob_cnt == 2'd0);
  assign pop_fire    = pop && !empty;
  assign ascii_char  = ob_ch[ob_rd];
  assign queue_empty = ob_empty[ob_rd];

  // Admit a read only when its result has a buffer slot
  assign inflight = ob_cnt + 2'(p_valid);
  assign issue_ok = (inflight < 2'(ps2s1_pkg::OB_DEPTH)) || pop_fire;
  assign op_take  = op_valid && (!op.is_read || issue_ok);
  assign do_write = op_take && !op.is_read && !ring_full;
  assign do_read  = op_take && op.is_read;

  // Ring storage with registered read
  always_ff @(posedge clk) begin
    if (do_write) begin
      ring[write_pointer] <= op.ch;
    end
    rd_data <= ring[read_pointer];
  end

  // Advance ring pointers and track the read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      p_valid       <= 1'b0;
    end else begin
      if (do_write) begin
        write_pointer <= wp_inc;
      end
      if (do_read && !ring_empty) begin
        read_pointer <= rp_inc;
      end
      p_valid <= do_read;
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      p_empty <= ring_empty;
    end
  end

  // Output buffer payload
  always_ff @(posedge clk) begin
    if (p_valid) begin
      ob_ch[ob_wr]    <= p_empty ? 7'h00 : rd_data;
      ob_empty[ob_wr] <= p_empty;
    end
  end

  // Output buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wr  <= 1'b0;
      ob_rd  <= 1'b0;
      ob_cnt <= 2'd0;
    end else begin
      if (p_valid) begin
        ob_wr <= !ob_wr;
      end
      if (pop_fire) begin
        ob_rd <= !ob_rd;
      end
      ob_cnt <= ob_cnt + 2'(p_valid) - 2'(pop_fire);
    end
  end

  // Results in flight never exceed the buffer
  a_inflight: assert property (@(posedge clk) disable iff (rst)
    inflight <= 2'(ps2s1_pkg::OB_DEPTH))
    else $error("result buffer overrun");

  // An empty read reports a zero character
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && queue_empty) |-> (ascii_char == 7'h00))
    else $error("empty read with nonzero character");

  // A dropped push leaves the write pointer in place
  a_drop_hold: assert property (@(posedge clk) disable iff (rst)
    (op_take && !op.is_read && ring_full) |=> $stable(write_pointer))
    else $error("write pointer moved on a dropped character");

  // A read on a nonempty ring moves the read pointer
  a_read_adv: assert property (@(posedge clk) disable iff (rst)
    (do_read && !ring_empty) |=> (read_pointer != $past(read_pointer)))
    else $error("read pointer held on a served read");

endmodule

`default_nettype wire

// ===== hw/rtl/ps2s1_opq_unused_guard.sv =====
// ----------------------------------------------------------------------------
// ps2s1_opq_unused_guard: port-level checker for the result channel
// Watches the top-level result handshake and result encoding.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2s1_opq_unused_guard (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       empty,
  input  wire logic       pop,
  input  wire logic [6:0] ascii_char,
  input  wire logic       queue_empty
);

  // A waiting result stays until popped
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(ascii_char) && $stable(queue_empty)))
    else $error("waiting result changed before pop");

  // A delivered character is never zero
  a_char_nonzero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !queue_empty) |-> (ascii_char != 7'h00))
    else $error("zero character delivered");

  // Out of reset no result waits
  a_reset_empty: assert property (@(posedge clk)
    $fell(rst) |-> empty)
    else $error("result present after reset");

endmodule

`default_nettype wire
